>>> rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// shared concurrent assertion macros for the checker file
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication or plain property, sampled on clk, quiet while in reset
`define CHK_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// a condition that must never be seen
`define CHK_NEVER(lbl, clk, rst_n, expr, msg) \
	`CHK_ASSERT(lbl, clk, rst_n, !(expr), msg)

`endif

>>> rtl/mos_pkg.sv
// ----------------------------------------------------------------------------
// mos_pkg
// shared constants, state codes and control structs of the median block
// ----------------------------------------------------------------------------
package mos_pkg;

	localparam int MAX_SAMPLES = 32;
	localparam int SAMPLE_W    = 10;
	localparam int CNT_W       = $clog2(MAX_SAMPLES + 1);
	localparam int IDX_W       = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RD_LO,
		ST_RD_HI,
		ST_DONE
	} mos_state_t;

	// controller to datapath
	typedef struct packed {
		logic ins;     // insert the accepted sample into the sorted row
		logic sel_hi;  // read address: upper middle entry
		logic ld_lo;   // capture lower middle entry
		logic ld_hi;   // capture upper middle entry
		logic ld_out;  // load result register, start a new set
	} mos_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic out_free;  // result register can take a new value this cycle
	} mos_sts_t;

endpackage

>>> rtl/mos_if.sv
// ----------------------------------------------------------------------------
// mos_if
// valid/ready channels for samples in and medians out
// ----------------------------------------------------------------------------
interface mos_in_if;
	import mos_pkg::*;

	logic                valid;
	logic                ready;
	logic [SAMPLE_W-1:0] sample;
	logic                last;

	modport source (output valid, output sample, output last, input ready);
	modport sink (input valid, input sample, input last, output ready);
endinterface

interface mos_out_if;
	import mos_pkg::*;

	logic                valid;
	logic                ready;
	logic [SAMPLE_W-1:0] median;

	modport source (output valid, output median, input ready);
	modport sink (input valid, input median, output ready);
endinterface

>>> rtl/mos_ctrl.sv
// ----------------------------------------------------------------------------
// mos_ctrl
// sequencer: takes samples, then walks the two middle reads and the result load
// ----------------------------------------------------------------------------
module mos_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  logic              in_last,
	output logic              in_ready,
	input  mos_pkg::mos_sts_t sts,
	output mos_pkg::mos_cmd_t cmd
);
	import mos_pkg::*;

	mos_state_t state_q;
	mos_state_t state_d;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state and commands
	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.ins = 1'b1;
					if (in_last) begin
						state_d = ST_RD_LO;
					end
				end
			end
			ST_RD_LO: begin
				cmd.ld_lo = 1'b1;
				state_d   = ST_RD_HI;
			end
			ST_RD_HI: begin
				cmd.sel_hi = 1'b1;
				cmd.ld_hi  = 1'b1;
				state_d    = ST_DONE;
			end
			ST_DONE: begin
				// wait until the previous median has left
				if (sts.out_free) begin
					cmd.ld_out = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

>>> rtl/mos_dp.sv
// ----------------------------------------------------------------------------
// mos_dp
// sorted insertion row, middle entry reads, averaging and result register
// ----------------------------------------------------------------------------
module mos_dp (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic [mos_pkg::SAMPLE_W-1:0] sample,
	input  mos_pkg::mos_cmd_t            cmd,
	output mos_pkg::mos_sts_t            sts,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [mos_pkg::SAMPLE_W-1:0] median
);
	import mos_pkg::*;

	logic [SAMPLE_W-1:0] store_q [MAX_SAMPLES];
	logic [CNT_W-1:0]    cnt_q;
	logic [MAX_SAMPLES-1:0] gt;
	logic                full;
	logic                do_ins;
	logic [CNT_W-1:0]    cnt_m1;
	logic [IDX_W-1:0]    rd_idx;
	logic [SAMPLE_W-1:0] lo_q;
	logic [SAMPLE_W-1:0] hi_q;
	logic [SAMPLE_W:0]   sum;
	logic [SAMPLE_W-1:0] median_q;
	logic                out_vld_q;

	assign full   = (cnt_q == CNT_W'(MAX_SAMPLES));
	assign do_ins = cmd.ins && !full;

	// insertion row: each cell either holds, takes its left neighbor or takes the sample
	for (genvar i = 0; i < MAX_SAMPLES; i++) begin : g_cell
		assign gt[i] = (CNT_W'(i) >= cnt_q) || (store_q[i] > sample);

		if (i == 0) begin : g_head
			always_ff @(posedge clk) begin
				if (do_ins && gt[i]) begin
					store_q[i] <= sample;
				end
			end
		end else begin : g_body
			always_ff @(posedge clk) begin
				if (do_ins && (CNT_W'(i) <= cnt_q) && gt[i]) begin
					store_q[i] <= gt[i-1] ? store_q[i-1] : sample;
				end
			end
		end
	end

	// fill count of the current set
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (cmd.ld_out) begin
			cnt_q <= '0;
		end else if (do_ins) begin
			cnt_q <= cnt_q + CNT_W'(1);
		end
	end

	// middle entries: lower at (n-1)/2, upper at n/2, same entry for odd n
	assign cnt_m1 = cnt_q - CNT_W'(1);
	assign rd_idx = cmd.sel_hi ? IDX_W'(cnt_q >> 1) : IDX_W'(cnt_m1 >> 1);

	always_ff @(posedge clk) begin
		if (cmd.ld_lo) begin
			lo_q <= store_q[rd_idx];
		end
		if (cmd.ld_hi) begin
			hi_q <= store_q[rd_idx];
		end
	end

	// truncated mean of the pair
	assign sum = {1'b0, lo_q} + {1'b0, hi_q};

	// result register
	always_ff @(posedge clk) begin
		if (cmd.ld_out) begin
			median_q <= sum[SAMPLE_W:1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (cmd.ld_out) begin
			out_vld_q <= 1'b1;
		end else if (out_ready) begin
			out_vld_q <= 1'b0;
		end
	end

	assign sts.out_free = !out_vld_q || out_ready;
	assign out_valid    = out_vld_q;
	assign median       = median_q;

endmodule

>>> rtl/median_of_sample_set_core.sv
// ----------------------------------------------------------------------------
// median_of_sample_set_core
// median of a set of 10-bit samples, kept sorted by an insertion row
// ----------------------------------------------------------------------------
// samples: one 10-bit reading per transfer, last marks the end of the set.
// result: one median per set, given after the transfer that carries last.
// up to MAX_SAMPLES samples are kept; later samples of a full set are dropped,
// but their last flag still closes the set.
// a sample without last does not stall: the whole row shifts in parallel.
// a sample with last starts these steps in order: insert, read the lower middle
// entry, read the upper middle entry, load the result register. the two reads
// are separate steps since the row has a single read port.
// even counts give the truncated mean of the two middle values.
// the result register lets new samples be taken while a median waits. a set end
// stalls samples (ready low) for the reads and until a waiting median transfers.
// reset empties the set and drops any pending median; no clearing pass is run.
// ----------------------------------------------------------------------------
module median_of_sample_set_core (
	input  logic      clk,
	input  logic      arst_n,
	mos_in_if.sink    samples,
	mos_out_if.source result
);
	import mos_pkg::*;

	mos_cmd_t cmd;
	mos_sts_t sts;

	// control
	mos_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (samples.valid),
		.in_last  (samples.last),
		.in_ready (samples.ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	// sorted store and result
	mos_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.sample    (samples.sample),
		.cmd       (cmd),
		.sts       (sts),
		.out_valid (result.valid),
		.out_ready (result.ready),
		.median    (result.median)
	);

endmodule

>>> rtl/mos_chk.sv
// ----------------------------------------------------------------------------
// mos_chk
// port level checks of the median block, bound to the top level
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module mos_chk (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         in_valid,
	input logic                         in_ready,
	input logic                         in_last,
	input logic                         out_valid,
	input logic                         out_ready,
	input logic [mos_pkg::SAMPLE_W-1:0] median
);
	import mos_pkg::*;

	// a pending median stays until its transfer
	`CHK_ASSERT(a_out_hold, clk, arst_n, out_valid && !out_ready |=> out_valid, "median dropped before transfer")

	// a stalled median keeps its value
	`CHK_ASSERT(a_out_stable, clk, arst_n, out_valid && !out_ready |=> $stable(median), "median changed while stalled")

	// closing a set blocks new samples during the two middle reads
	`CHK_ASSERT(a_last_busy, clk, arst_n, in_valid && in_ready && in_last |=> !in_ready ##1 !in_ready, "sample taken during median read")

	// a new median is only seen after samples have been held blocked
	`CHK_ASSERT(a_out_origin, clk, arst_n, $rose(out_valid) |-> !$past(in_ready) && !$past(in_ready, 2), "median appeared without a closed set")

endmodule

bind median_of_sample_set_core mos_chk u_mos_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (samples.valid),
	.in_ready  (samples.ready),
	.in_last   (samples.last),
	.out_valid (result.valid),
	.out_ready (result.ready),
	.median    (result.median)
);

>>> bench/tb.sv
// ----------------------------------------------------------------------------
// tb
// self-checking bench for median_of_sample_set_core
// ----------------------------------------------------------------------------
// sample sets are sent over the valid/ready input channel, and every accepted
// transfer that fits also updates a local sorted copy of the set. a transfer
// that carries last queues the expected median. each result transfer is
// compared with the oldest queued median. both channels idle at random, with
// some stretches held free of gaps.
// ----------------------------------------------------------------------------
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import mos_pkg::*;

	localparam int CYCLE_LIMIT  = 300000;
	localparam int DRAIN_CYCLES = 12;

	typedef enum int {
		PAT_RANDOM,
		PAT_CLUSTER,
		PAT_RISING,
		PAT_FALLING,
		PAT_EXTREMES,
		PAT_FLAT
	} value_pattern_t;

	logic clk;
	logic arst_n;

	mos_in_if  samples_ch ();
	mos_out_if result_ch ();

	median_of_sample_set_core dut (
		.clk    (clk),
		.arst_n (arst_n),
		.samples(samples_ch),
		.result (result_ch)
	);

	// local copy of the sorted set and the medians still to arrive
	logic [SAMPLE_W-1:0] held_row [MAX_SAMPLES];
	int                  held_count = 0;
	logic [SAMPLE_W-1:0] pending_medians [$];
	logic [SAMPLE_W-1:0] expected_median;

	int mismatches  = 0;
	int cycle_count = 0;
	int rx_gap;
	bit tx_idle_en = 1'b1;
	bit rx_idle_en = 1'b1;

	// clock
	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// idle length: mostly none or short, a few long
	function automatic int pick_gap(input bit enable);
		int r;
		r = $urandom_range(0, 99);
		if (!enable || r < 50)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(6, 30);
	endfunction

	// insert an accepted sample into the sorted copy; on last, queue the median
	function automatic void predict_transfer(input logic [SAMPLE_W-1:0] value,
			input logic is_last);
		int                pos;
		logic [SAMPLE_W:0] pair_sum;
		if (held_count < MAX_SAMPLES) begin
			pos = held_count;
			while (pos > 0 && held_row[pos-1] > value) begin
				held_row[pos] = held_row[pos-1];
				pos--;
			end
			held_row[pos] = value;
			held_count++;
		end
		if (is_last) begin
			if (held_count % 2 == 1) begin
				pending_medians.push_back(held_row[(held_count - 1) / 2]);
			end else begin
				pair_sum = {1'b0, held_row[held_count/2]} + {1'b0, held_row[held_count/2 - 1]};
				pending_medians.push_back(pair_sum[SAMPLE_W:1]);
			end
			held_count = 0;
		end
	endfunction

	// one sample transfer, with an optional idle gap in front
	task automatic send_sample(input logic [SAMPLE_W-1:0] value, input logic is_last);
		int gap;
		gap = pick_gap(tx_idle_en);
		if (gap > 0) begin
			samples_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		samples_ch.valid  <= 1'b1;
		samples_ch.sample <= value;
		samples_ch.last   <= is_last;
		do @(posedge clk); while (!samples_ch.ready);
		predict_transfer(value, is_last);
	endtask

	// sets of one sample, extremes and alternating bits
	task automatic test_single_sample_sets();
		send_sample(10'd0, 1'b1);
		send_sample(10'd1023, 1'b1);
		send_sample(10'h2AA, 1'b1);
		send_sample(10'h155, 1'b1);
	endtask

	// even sets with truncated mean, odd set given out of order
	task automatic test_middle_values();
		send_sample(10'd1023, 1'b0);
		send_sample(10'd0, 1'b1);
		send_sample(10'd1022, 1'b0);
		send_sample(10'd1023, 1'b1);
		send_sample(10'd1, 1'b0);
		send_sample(10'd0, 1'b1);
		send_sample(10'd900, 1'b0);
		send_sample(10'd3, 1'b0);
		send_sample(10'd500, 1'b1);
	endtask

	// fill the store, then two dropped samples, last on the final dropped one
	task automatic test_full_store();
		for (int i = 0; i < MAX_SAMPLES + 2; i++) begin
			if (i < MAX_SAMPLES)
				send_sample(SAMPLE_W'(1023 - i * 33), 1'b0);
			else
				send_sample(10'd0, i == MAX_SAMPLES + 1);
		end
	endtask

	// set ends back to back, with no idle gaps in front of the samples
	task automatic test_back_to_back_ends();
		tx_idle_en = 1'b0;
		for (int i = 0; i < 8; i++)
			send_sample(SAMPLE_W'($urandom_range(0, 1023)), 1'b1);
		tx_idle_en = 1'b1;
	endtask

	// random sets, mostly inside the store depth, some overflowing it
	task automatic test_random_sets(input int item_budget);
		int             sent;
		int             set_len;
		int             base;
		int             v;
		int             r;
		value_pattern_t pattern;
		sent = 0;
		while (sent < item_budget) begin
			r = $urandom_range(0, 99);
			if (r < 12)
				set_len = 1;
			else if (r < 72)
				set_len = $urandom_range(2, 16);
			else if (r < 90)
				set_len = $urandom_range(17, MAX_SAMPLES);
			else
				set_len = $urandom_range(MAX_SAMPLES + 1, MAX_SAMPLES + 8);
			pattern    = value_pattern_t'($urandom_range(0, 5));
			base       = $urandom_range(0, 1023 - 48);
			tx_idle_en = ($urandom_range(0, 3) != 0);
			rx_idle_en = ($urandom_range(0, 3) != 0);
			for (int i = 0; i < set_len; i++) begin
				case (pattern)
					PAT_CLUSTER:  v = base + $urandom_range(0, 3);
					PAT_RISING:   v = base + i;
					PAT_FALLING:  v = base + 48 - i;
					PAT_EXTREMES: v = $urandom_range(0, 1) ? 1023 : 0;
					PAT_FLAT:     v = base;
					default:      v = $urandom_range(0, 1023);
				endcase
				send_sample(v[SAMPLE_W-1:0], i == set_len - 1);
			end
			sent += set_len;
		end
		tx_idle_en = 1'b1;
		rx_idle_en = 1'b1;
	endtask

	// result side ready with random stalls
	initial begin
		forever begin
			rx_gap = pick_gap(rx_idle_en);
			if (rx_gap > 0) begin
				result_ch.ready <= 1'b0;
				repeat (rx_gap) @(posedge clk);
			end
			result_ch.ready <= 1'b1;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
	end

	// compare each result transfer with the oldest queued median
	always @(posedge clk) begin
		if (arst_n && result_ch.valid && result_ch.ready) begin
			if (pending_medians.size() == 0) begin
				$display("%0t unexpected median: expected none, actual %0d",
					$time, result_ch.median);
				mismatches++;
			end else begin
				expected_median = pending_medians.pop_front();
				if (result_ch.median !== expected_median) begin
					$display("%0t median mismatch: expected %0d, actual %0d",
						$time, expected_median, result_ch.median);
					mismatches++;
				end
			end
		end
	end

	// run limit
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("%0t timeout with %0d medians outstanding",
				$time, pending_medians.size());
			$display("CHECKS FAILED");
			$finish;
		end
	end

	// reset, tests in turn, drain, verdict
	initial begin
		arst_n = 1'b0;
		samples_ch.valid  <= 1'b0;
		samples_ch.sample <= '0;
		samples_ch.last   <= 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_single_sample_sets();
		test_middle_values();
		test_full_store();
		test_back_to_back_ends();
		test_random_sets(700);

		samples_ch.valid <= 1'b0;
		while (pending_medians.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (mismatches == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule

>>> filelist.f
+incdir+rtl
rtl/mos_pkg.sv
rtl/mos_if.sv
rtl/mos_ctrl.sv
rtl/mos_dp.sv
rtl/median_of_sample_set_core.sv
rtl/mos_chk.sv
bench/tb.sv
